>>> sv/sbts_pkg.sv
// ----------------------------------------------------------------------------
// sbts_pkg: shared types and constants for the sparse block taint store
// Holds the store geometry, the stream field layout and the record formats
// that pass between the row update logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sbts_pkg;

    // Store geometry (BUCKETS must be a power of two)
    localparam int BUCKETS     = 1024;
    localparam int WAYS        = 4;
    localparam int BLOCK_BITS  = 40;
    localparam int DEVICE_BITS = 8;
    localparam int IDX_W       = $clog2(BUCKETS);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BITMAP_W    = 64;

    // Input field widths as seen on the stream
    localparam int BLK_IN_W   = 40;
    localparam int DEV_IN_W   = 8;
    localparam int TAINT_W    = 32;
    localparam int OFF_W      = 6;
    localparam int SIZE_W     = 7;

    // Input tdata layout, lowest field first
    localparam int BLK_LSB    = 0;
    localparam int DEV_LSB    = BLK_LSB + BLK_IN_W;
    localparam int TAINT_LSB  = DEV_LSB + DEV_IN_W;
    localparam int OFF_LSB    = TAINT_LSB + TAINT_W;
    localparam int SIZE_LSB   = OFF_LSB + OFF_W;
    localparam int S_USED_W   = SIZE_LSB + SIZE_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first
    localparam int M_USED_W   = TAINT_W + 2;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        OP_SET   = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        ST_CLEAR,
        ST_RUN
    } state_t;

    // One way of a bucket row
    typedef struct packed {
        logic                   valid;
        logic [BLOCK_BITS-1:0]  blk;
        logic [DEVICE_BITS-1:0] dev;
        logic [BITMAP_W-1:0]    bitmap;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    // Item held in the update stage
    typedef struct packed {
        op_t                    op;
        logic [BLOCK_BITS-1:0]  blk;
        logic [DEVICE_BITS-1:0] dev;
        logic [TAINT_W-1:0]     taint;
        logic [OFF_W-1:0]       off;
        logic [SIZE_W-1:0]      size;
    } req_t;

    // Result of one item
    typedef struct packed {
        logic [TAINT_W-1:0] read_taint;
        logic               entry_found;
        logic               record_dropped;
    } rsp_t;

endpackage

`default_nettype wire

>>> sv/sbts_row_ram.sv
// ----------------------------------------------------------------------------
// sbts_row_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sbts_row_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/sbts_update.sv
// ----------------------------------------------------------------------------
// sbts_update: read-modify-write logic for one bucket row
// Matches the item against every way, applies a set or a check to the
// matching bitmap, allocates or frees a way, and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sbts_update (
    input  wire sbts_pkg::req_t req,
    input  wire sbts_pkg::row_t row_in,
    output sbts_pkg::row_t      row_out,
    output logic                wr_en,
    output sbts_pkg::rsp_t      rsp
);
    import sbts_pkg::*;

    logic [WAYS-1:0]     hit_vec;
    logic [WAYS-1:0]     free_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic                found;
    logic                has_free;
    logic                taint_nz;
    logic [3:0]          folded;
    logic [BITMAP_W-1:0] old_bm;
    logic [BITMAP_W-1:0] size_ones;
    logic [BITMAP_W-1:0] clr_mask;
    logic [BITMAP_W-1:0] ins_bits;
    logic [BITMAP_W-1:0] kept_bm;
    logic [BITMAP_W-1:0] shifted;
    logic [7:0]          win_end;
    logic [SIZE_W-1:0]   eff;
    logic [3:0]          mask4;
    logic [3:0]          win4;
    logic [TAINT_W-1:0]  expanded;

    // Match every way; pick the lowest hit and the lowest free way
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]  = row_in[w].valid && (row_in[w].blk == req.blk) &&
                          (row_in[w].dev == req.dev);
            free_vec[w] = !row_in[w].valid;
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_way = WAY_W'(w);
            end
        end
        found    = |hit_vec;
        has_free = |free_vec;
        old_bm   = row_in[hit_way].bitmap;
    end

    // Fold the byte taint to one bit per byte and build the window masks
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            folded[k] = |req.taint[8*k +: 8];
        end
        taint_nz  = |req.taint;
        size_ones = (req.size >= SIZE_W'(BITMAP_W)) ? '1 :
                    ((BITMAP_W'(1) << req.size[OFF_W-1:0]) - BITMAP_W'(1));
        clr_mask  = size_ones << req.off;
        ins_bits  = BITMAP_W'(folded) << req.off;
        kept_bm   = old_bm & ~clr_mask;
    end

    // Check window, clamped to the block end, low four bits only
    always_comb begin
        win_end  = 8'(req.off) + 8'(req.size);
        eff      = (win_end > 8'(BITMAP_W)) ? SIZE_W'(BITMAP_W - int'(req.off)) : req.size;
        mask4    = (eff >= SIZE_W'(4)) ? 4'hF : 4'((5'd1 << eff[1:0]) - 5'd1);
        shifted  = old_bm >> req.off;
        win4     = shifted[3:0] & mask4 & {4{found && (req.op == OP_CHECK)}};
        for (int k = 0; k < 4; k++) begin
            expanded[8*k +: 8] = {8{win4[k]}};
        end
    end

    // Modify the row for a set item
    always_comb begin
        row_out             = row_in;
        wr_en               = 1'b0;
        rsp.read_taint      = expanded;
        rsp.entry_found     = found;
        rsp.record_dropped  = 1'b0;
        if (req.op == OP_SET) begin
            if (found) begin
                wr_en = 1'b1;
                if (taint_nz) begin
                    row_out[hit_way].bitmap = kept_bm | ins_bits;
                end else if (kept_bm == '0) begin
                    row_out[hit_way].valid  = 1'b0;
                    row_out[hit_way].bitmap = '0;
                end else begin
                    row_out[hit_way].bitmap = kept_bm;
                end
            end else if (taint_nz) begin
                if (has_free) begin
                    wr_en                    = 1'b1;
                    row_out[free_way].valid  = 1'b1;
                    row_out[free_way].blk    = req.blk;
                    row_out[free_way].dev    = req.dev;
                    row_out[free_way].bitmap = ins_bits;
                end else begin
                    rsp.record_dropped = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/sparse_block_taint_store.sv
// ----------------------------------------------------------------------------
// sparse_block_taint_store: hashed per-block taint bitmap store
// One RAM row per bucket holds all ways; items read the row, modify it and
// write it back, with a forwarding register for back-to-back same-bucket use.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                          Content
//  s_        in         s_tvalid s_tready s_tdata      set / check item
//                       s_tuser                        op
//  m_        out        m_tvalid m_tready m_tdata      one result per item
//
//  One item per cycle while results drain; from input transfer to result
//  an item passes the row read, then update and write-back through the
//  output reg. After reset a clearing pass writes every bucket row, with
//  s_tready low. A stalled result holds the update stage; the row RAM
//  port is the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_block_taint_store (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // block_index[39:0], device_id[47:40], taint_word[79:48],
    // byte_offset[85:80], access_size[92:86]
    input  wire logic [sbts_pkg::S_TDATA_W-1:0]  s_tdata,
    // op
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // read_taint[31:0], entry_found[32], record_dropped[33]
    output logic      [sbts_pkg::M_TDATA_W-1:0]  m_tdata
);
    import sbts_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_active;
    logic             clr_last;

    req_t             in_req;
    logic             s_xfer;
    req_t             s1_req_reg;
    logic             s1_valid_reg;
    logic             s1_go;

    logic             fwd_hit_reg;
    row_t             fwd_row_reg;
    row_t             rd_row;
    row_t             cur_row;
    row_t             new_row;
    logic             upd_wr;
    rsp_t             upd_rsp;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    row_t             mem_wdata;

    logic             m_tvalid_reg;
    rsp_t             m_rsp_reg;

    // Unpack the input transfer
    always_comb begin
        in_req.op    = op_t'(s_tuser);
        in_req.blk   = BLOCK_BITS'(s_tdata[BLK_LSB +: BLK_IN_W]);
        in_req.dev   = DEVICE_BITS'(s_tdata[DEV_LSB +: DEV_IN_W]);
        in_req.taint = s_tdata[TAINT_LSB +: TAINT_W];
        in_req.off   = s_tdata[OFF_LSB +: OFF_W];
        in_req.size  = s_tdata[SIZE_LSB +: SIZE_W];
    end

    // Clearing pass sequencer: next state
    always_comb begin
        clr_last     = (clr_cnt_reg == IDX_W'(BUCKETS - 1));
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_last) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Clearing pass sequencer: outputs
    always_comb begin
        unique case (state_reg)
            ST_CLEAR: clr_active = 1'b1;
            ST_RUN:   clr_active = 1'b0;
            default:  clr_active = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Handshake: advance the update stage when the output register is free
    assign s1_go    = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !clr_active && (!s1_valid_reg || s1_go);
    assign s_xfer   = s_tvalid && s_tready;

    // Row RAM write: clearing pass or write-back of the update stage
    always_comb begin
        if (clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_go && upd_wr;
            mem_waddr = s1_req_reg.blk[IDX_W-1:0];
            mem_wdata = new_row;
        end
    end

    sbts_row_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (ROW_W)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (s_xfer),
        .rd_addr (in_req.blk[IDX_W-1:0]),
        .rd_data (rd_row)
    );

    // Update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= 1'b1;
            fwd_hit_reg  <= mem_we && (mem_waddr == in_req.blk[IDX_W-1:0]);
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
    end

    // Update stage payload; capture the row written in the same cycle
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_req_reg  <= in_req;
            fwd_row_reg <= mem_wdata;
        end
    end

    // Forward the row written as this item's read was taken
    assign cur_row = fwd_hit_reg ? fwd_row_reg : rd_row;

    sbts_update u_update (
        .req     (s1_req_reg),
        .row_in  (cur_row),
        .row_out (new_row),
        .wr_en   (upd_wr),
        .rsp     (upd_rsp)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            m_rsp_reg <= upd_rsp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_rsp_reg.record_dropped, m_rsp_reg.entry_found,
                                  m_rsp_reg.read_taint});

    // Checks
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_fwd_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forwarding flag set with empty update stage");

    a_drop_is_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_rsp_reg.record_dropped |-> !m_rsp_reg.entry_found)
        else $error("record dropped although a match existed");

    a_taint_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_rsp_reg.read_taint != '0) |-> m_rsp_reg.entry_found)
        else $error("taint reported without a matching record");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("update stage lost its item while stalled");

endmodule

`default_nettype wire
